[hw/rtl/qpn_pkg.sv]
// Package for the quaternion product and normalise pipeline.
// Holds the component width, derived widths, word types and the pipeline latency.
// No dependencies.
package qpn_pkg;

  // Component width: signed fixed point with one integer bit.
  localparam int CW = 16;
  localparam int FB = CW - 1;

  // Partial products are pre-shifted only when the sums would not fit 64 bits.
  localparam int G  = (2 * CW > 62) ? (2 * CW - 62) : 0;
  localparam int PW = 2 * CW - G;
  localparam int SW = PW + 2;

  // Normalisation and root widths.
  localparam int MAG_W = 64;
  localparam int UN_W  = 31;
  localparam int SQ_W  = 64;
  localparam int RT_W  = 32;

  // Divider widths: dividend and quotient.
  localparam int DW = RT_W + FB;
  localparam int QB = FB + 1;

  localparam logic [CW-1:0] MAXMAG = CW'((64'd1 << FB) - 64'd1);
  localparam logic [CW-1:0] MINVAL = CW'(64'd1 << FB);

  // Cycles from an accepted input word to its result strobe.
  localparam int PIPE_LAT = 7 + (SQ_W / 2) + 1 + QB + 1;

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] a_w;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] b_w;
  } qpn_in_t;

  typedef struct packed {
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;
    logic signed [CW-1:0] r_w;
    logic                 zero_norm;
  } qpn_out_t;

endpackage

[hw/rtl/qpn_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on qpn_pkg for the radicand and root widths.
module qpn_sqrt import qpn_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid_in,
  input  logic [SQ_W-1:0] radicand,
  output logic            valid_out,
  output logic [RT_W-1:0] root
);

  localparam int NST = SQ_W / 2;

  logic            v    [NST];
  logic [SQ_W-1:0] rad  [NST];
  logic [RT_W+2:0] rem  [NST];
  logic [RT_W-1:0] rt   [NST];

  for (genvar i = 0; i < NST; i++) begin : g_stage
    logic            v_in;
    logic [SQ_W-1:0] rad_in;
    logic [RT_W+2:0] rem_in;
    logic [RT_W-1:0] rt_in;
    logic [RT_W+2:0] cat;
    logic [RT_W+2:0] trial;
    logic            ge;

    if (i == 0) begin : g_first
      assign v_in   = valid_in;
      assign rad_in = radicand;
      assign rem_in = '0;
      assign rt_in  = '0;
    end else begin : g_next
      assign v_in   = v[i-1];
      assign rad_in = rad[i-1];
      assign rem_in = rem[i-1];
      assign rt_in  = rt[i-1];
    end

    // Bring down the next two radicand bits and try the trial subtrahend.
    assign cat   = {rem_in[RT_W:0], rad_in[SQ_W-1 -: 2]};
    assign trial = {1'b0, rt_in, 2'b01};
    assign ge    = (cat >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else begin
        v[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rad[i] <= rad_in << 2;
      rem[i] <= ge ? (cat - trial) : cat;
      rt[i]  <= {rt_in[RT_W-2:0], ge};
    end
  end

  assign valid_out = v[NST-1];
  assign root      = rt[NST-1];

endmodule

[hw/rtl/qpn_div.sv]
// Pipelined restoring divider lane, one quotient bit per stage.
// Depends on qpn_pkg for the dividend, divisor and quotient widths.
module qpn_div import qpn_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid_in,
  input  logic [DW-1:0]   dividend,
  input  logic [RT_W-1:0] divisor,
  output logic            valid_out,
  output logic [QB-1:0]   quot
);

  logic            v   [QB];
  logic [RT_W-1:0] rem [QB];
  logic [QB-1:0]   low [QB];
  logic [QB-1:0]   q   [QB];
  logic [RT_W-1:0] den [QB];

  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic            v_in;
    logic [RT_W-1:0] rem_in;
    logic [QB-1:0]   low_in;
    logic [QB-1:0]   q_in;
    logic [RT_W-1:0] den_in;
    logic [RT_W:0]   cat;
    logic [RT_W:0]   diff;
    logic            ge;

    // The upper dividend bits are known to be below the divisor.
    if (j == 0) begin : g_first
      assign v_in   = valid_in;
      assign rem_in = RT_W'(dividend[DW-1:QB]);
      assign low_in = dividend[QB-1:0];
      assign q_in   = '0;
      assign den_in = divisor;
    end else begin : g_next
      assign v_in   = v[j-1];
      assign rem_in = rem[j-1];
      assign low_in = low[j-1];
      assign q_in   = q[j-1];
      assign den_in = den[j-1];
    end

    // Shift in one dividend bit and subtract where the divisor fits.
    assign cat  = {rem_in, low_in[QB-1]};
    assign diff = cat - {1'b0, den_in};
    assign ge   = (cat >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else begin
        v[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem[j] <= ge ? diff[RT_W-1:0] : cat[RT_W-1:0];
      low[j] <= low_in << 1;
      q[j]   <= {q_in[QB-2:0], ge};
      den[j] <= den_in;
    end
  end

  assign valid_out = v[QB-1];
  assign quot      = q[QB-1];

endmodule

[hw/rtl/quaternion_product_normalize.sv]
// Quaternion product B*A followed by normalisation to unit length.
// Depends on qpn_pkg, qpn_sqrt and qpn_div.
//
//   channel   handshake       word        direction
//   input     start / busy    operands    in, taken when start is high and busy low
//   result    done            result      out, one cycle per word, not stallable
//
// A word is taken every cycle; busy is never raised.
// The front stages form the products, sums, sign and magnitude, two normalising
// shift steps, the squares and their sum; then follow 32 root stages, the
// dividend register, one divider stage per quotient bit and the output register.
// Synchronous reset clears every valid bit; data registers are not reset.
module quaternion_product_normalize import qpn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  qpn_in_t  operands,
  output logic     done,
  output qpn_out_t result
);

  localparam int UD_LEN = 2 + SQ_W / 2;
  localparam int FD_LEN = UD_LEN + 1 + QB;

  typedef struct packed {
    logic [3:0] neg;
    logic       zero;
  } flag_t;

  logic signed [PW-1:0] p1 [4][4];
  logic signed [SW-1:0] s2 [4];
  logic [MAG_W-1:0]     m3 [4];
  logic [MAG_W-1:0]     m4 [4];
  logic [MAG_W-1:0]     m4_next [4];
  logic [MAG_W-1:0]     o4, o4_next;
  logic [UN_W-1:0]      u5 [4];
  logic [UN_W-1:0]      u5_next [4];
  logic [2*UN_W-1:0]    sq6 [4];
  logic [SQ_W-1:0]      s7;
  logic [3:0]           neg3, neg4, neg5;
  logic                 zero4, zero5;
  logic                 v1, v2, v3, v4, v5, v6, v7;
  logic                 vs, vd;
  logic [RT_W-1:0]      n_root;
  logic [3:0][UN_W-1:0] ud [UD_LEN];
  flag_t                fd [FD_LEN];
  logic [DW-1:0]        dd [4];
  logic [RT_W-1:0]      nd;
  logic [3:0]           vq;
  logic [QB-1:0]        quot [4];
  logic [CW-1:0]        rmag [4];
  logic [CW-1:0]        rval [4];

  assign busy = 1'b0;

  // Valid bits travel alongside the data through the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      vd <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      vd <= vs;
    end
  end

  // Stage one: the sixteen partial products, pre-shifted only at full width.
  function automatic logic signed [PW-1:0] pprod(input logic signed [CW-1:0] x,
                                                 input logic signed [CW-1:0] y);
    logic signed [2*CW-1:0] full;
    full  = x * y;
    pprod = PW'(full >>> G);
  endfunction

  always_ff @(posedge clk) begin
    p1[0][0] <= pprod(operands.b_w, operands.a_x);
    p1[0][1] <= pprod(operands.b_x, operands.a_w);
    p1[0][2] <= pprod(operands.b_y, operands.a_z);
    p1[0][3] <= pprod(operands.b_z, operands.a_y);
    p1[1][0] <= pprod(operands.b_w, operands.a_y);
    p1[1][1] <= pprod(operands.b_y, operands.a_w);
    p1[1][2] <= pprod(operands.b_z, operands.a_x);
    p1[1][3] <= pprod(operands.b_x, operands.a_z);
    p1[2][0] <= pprod(operands.b_w, operands.a_z);
    p1[2][1] <= pprod(operands.b_z, operands.a_w);
    p1[2][2] <= pprod(operands.b_x, operands.a_y);
    p1[2][3] <= pprod(operands.b_y, operands.a_x);
    p1[3][0] <= pprod(operands.b_w, operands.a_w);
    p1[3][1] <= pprod(operands.b_x, operands.a_x);
    p1[3][2] <= pprod(operands.b_y, operands.a_y);
    p1[3][3] <= pprod(operands.b_z, operands.a_z);
  end

  // Stage two: exact component sums in Hamilton order.
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      s2[c] <= SW'(p1[c][0]) + SW'(p1[c][1]) + SW'(p1[c][2]) - SW'(p1[c][3]);
    end
    s2[3] <= SW'(p1[3][0]) - SW'(p1[3][1]) - SW'(p1[3][2]) - SW'(p1[3][3]);
  end

  // Stage three: sign and magnitude.
  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      logic [SW-1:0] mag;
      neg3[c] <= s2[c][SW-1];
      mag      = s2[c][SW-1] ? SW'(-s2[c]) : SW'(s2[c]);
      m3[c]   <= MAG_W'(mag);
    end
  end

  // Stage four: zero detect and the coarse steps of the shared left shift.
  always_comb begin
    o4_next = m3[0] | m3[1] | m3[2] | m3[3];
    for (int c = 0; c < 4; c++) begin
      m4_next[c] = m3[c];
    end
    for (int t = 0; t < 3; t++) begin
      if ((o4_next >> (MAG_W - (32 >> t))) == '0) begin
        o4_next = o4_next << (32 >> t);
        for (int c = 0; c < 4; c++) begin
          m4_next[c] = m4_next[c] << (32 >> t);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    o4    <= o4_next;
    m4    <= m4_next;
    neg4  <= neg3;
    zero4 <= (m3[0] | m3[1] | m3[2] | m3[3]) == '0;
  end

  // Stage five: fine shift steps; the top bits are the normalised magnitudes.
  always_comb begin
    logic [MAG_W-1:0] orv;
    logic [MAG_W-1:0] mv [4];
    orv = o4;
    mv  = m4;
    for (int t = 0; t < 3; t++) begin
      if ((orv >> (MAG_W - (4 >> t))) == '0) begin
        orv = orv << (4 >> t);
        for (int c = 0; c < 4; c++) begin
          mv[c] = mv[c] << (4 >> t);
        end
      end
    end
    for (int c = 0; c < 4; c++) begin
      u5_next[c] = mv[c][MAG_W-1 -: UN_W];
    end
  end

  always_ff @(posedge clk) begin
    u5    <= u5_next;
    neg5  <= neg4;
    zero5 <= zero4;
  end

  // Stages six and seven: squares, then their sum.
  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      sq6[c] <= u5[c] * u5[c];
    end
    s7 <= SQ_W'(sq6[0]) + SQ_W'(sq6[1]) + SQ_W'(sq6[2]) + SQ_W'(sq6[3]);
  end

  qpn_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (v7),
    .radicand  (s7),
    .valid_out (vs),
    .root      (n_root)
  );

  // Magnitudes and flags wait alongside the root and the divider.
  always_ff @(posedge clk) begin
    ud[0] <= {u5[3], u5[2], u5[1], u5[0]};
    for (int k = 1; k < UD_LEN; k++) begin
      ud[k] <= ud[k-1];
    end
    fd[0] <= '{neg: neg5, zero: zero5};
    for (int k = 1; k < FD_LEN; k++) begin
      fd[k] <= fd[k-1];
    end
  end

  // Dividend for round half up: magnitude scaled by the fraction, plus half the norm.
  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      dd[c] <= DW'({ud[UD_LEN-1][c], {FB{1'b0}}}) + DW'(n_root >> 1);
    end
    nd <= n_root;
  end

  for (genvar c = 0; c < 4; c++) begin : g_lane
    qpn_div u_div (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (vd),
      .dividend  (dd[c]),
      .divisor   (nd),
      .valid_out (vq[c]),
      .quot      (quot[c])
    );
  end

  // Saturate, restore the sign and substitute the identity for a zero product.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      rmag[c] = quot[c][FB] ? MAXMAG : CW'(quot[c][FB-1:0]);
      rval[c] = fd[FD_LEN-1].neg[c] ? CW'(-rmag[c]) : rmag[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vq[0];
    end
  end

  always_ff @(posedge clk) begin
    if (fd[FD_LEN-1].zero) begin
      result <= '{r_x: '0, r_y: '0, r_z: '0, r_w: MAXMAG, zero_norm: 1'b1};
    end else begin
      result <= '{r_x: rval[0], r_y: rval[1], r_z: rval[2], r_w: rval[3],
                  zero_norm: 1'b0};
    end
  end

endmodule

[hw/rtl/qpn_checker.sv]
// Port-level checks for the quaternion product and normalise block, and its bind.
// Depends on qpn_pkg for the latency and the saturation limits.
module qpn_checker import qpn_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input qpn_in_t  operands,
  input logic     done,
  input qpn_out_t result
);

  // Every accepted word yields its result a fixed number of cycles later.
  a_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LAT done)
    else $error("accepted word produced no result");

  // No result appears without a word accepted at the right time.
  a_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result without matching input word");

  // A zero product gives exactly the identity.
  a_ident: assert property (@(posedge clk) disable iff (rst)
    (done && result.zero_norm) |-> (result.r_x == '0 && result.r_y == '0 &&
                                    result.r_z == '0 && result.r_w == MAXMAG))
    else $error("zero product did not give the identity");

  // Saturation never lets the most negative code through.
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.r_x != MINVAL && result.r_y != MINVAL &&
              result.r_z != MINVAL && result.r_w != MINVAL))
    else $error("result component outside the clamped range");

endmodule

bind quaternion_product_normalize qpn_checker u_qpn_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .operands (operands),
  .done     (done),
  .result   (result)
);
